// ===== hw/rtl/jan_pkg.sv =====
`default_nettype none

package jan_pkg;

  // field widths
  localparam int RAW_W       = 16;  // raw sample and calibration registers
  localparam int POS_W       = 8;   // signed position in hundredths
  localparam int OUT_TDATA_W = 16;  // position + no_signal, padded to bytes
  localparam int SAMPLE_BITS_DEF = 16;

  // signed difference of two raw values, and the divider operands
  localparam int DIFF_W = RAW_W + 1;
  localparam int QBITS  = 7;        // quotient bits below saturation (q < 128)
  localparam int DEN_W  = RAW_W + 1;  // 2*|den|
  localparam int NUM_W  = 24;         // 200*|num| + |den|

  localparam int unsigned SCALE2 = 200;  // 2 * 100, rounding numerator scale

  localparam logic signed [POS_W-1:0] POS_MAX = 8'sd100;
  localparam logic signed [POS_W-1:0] POS_MIN = -8'sd100;
  localparam logic        [QBITS-1:0] Q_MAX   = 7'd100;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RAW     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_RAW  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RAW     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRUST_MODE = 2'd3;

  // register reset values
  localparam logic [RAW_W-1:0] MIN_RAW_RST    = 16'd0;
  localparam logic [RAW_W-1:0] CENTER_RAW_RST = 16'd32767;
  localparam logic [RAW_W-1:0] MAX_RAW_RST    = 16'd65535;

  // side information that rides along with the divider
  typedef struct packed {
    logic                    ovr;      // result fixed, quotient ignored
    logic signed [POS_W-1:0] ovr_pos;  // fixed result
    logic                    nosig;    // raw sample was zero
    logic                    neg;      // quotient is negative
    logic                    thrust;   // unipolar clamp 0..100
  } jan_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jan_div.sv =====
`default_nettype none

// Pipelined restoring divider: q = floor(num/den), one quotient bit a stage.
// Stage 0 flags q >= 2^QBITS as saturated.
module jan_div import jan_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [DEN_W-1:0] in_den,
  input  wire jan_side_t        in_side,
  output logic                  out_valid,
  output logic [QBITS-1:0]      out_q,
  output logic                  out_sat,
  output jan_side_t             out_side
);

  localparam int NST = QBITS + 1;

  logic             v_r    [NST];
  logic [NUM_W-1:0] rem_r  [NST];
  logic [DEN_W-1:0] den_r  [NST];
  logic [QBITS-1:0] q_r    [NST];
  logic             sat_r  [NST];
  jan_side_t        side_r [NST];

  logic sat0;
  assign sat0 = in_num >= (NUM_W'(in_den) << QBITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_num;
      den_r[0]  <= in_den;
      q_r[0]    <= '0;
      sat_r[0]  <= sat0;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_bit
    localparam int B = QBITS - k;
    logic [NUM_W-1:0] sub;
    logic             ge;

    assign sub = NUM_W'(den_r[k-1]) << B;
    assign ge  = rem_r[k-1] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_r[k-1] - sub) : rem_r[k-1];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= q_r[k-1] | (ge ? (QBITS'(1) << B) : '0);
        sat_r[k]  <= sat_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_q     = q_r[NST-1];
  assign out_sat   = sat_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

`default_nettype wire

// ===== hw/rtl/joystick_axis_normalizer.sv =====
`default_nettype none

// Throughput: one word per cycle; the whole pipeline holds while the
//   output register is full and not taken.
// Reset (rst_n low, synchronous): all stage valids and out_tvalid clear,
//   calibration returns to min 0, center 32767, max 65535, bipolar mode.
module joystick_axis_normalizer import jan_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [RAW_W-1:0]      cfg_wdata,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [RAW_W-1:0]      in_tdata,   // [15:0] raw_sample
  // output stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_TDATA_W-1:0]     out_tdata   // [7:0] position, [8] no_signal
);

  localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [RAW_W-1:0] min_raw_r, center_raw_r, max_raw_r;
  logic             thrust_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_raw_r     <= MIN_RAW_RST;
      center_raw_r  <= CENTER_RAW_RST;
      max_raw_r     <= MAX_RAW_RST;
      thrust_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_MIN_RAW:     min_raw_r     <= cfg_wdata;
        CFG_CENTER_RAW:  center_raw_r  <= cfg_wdata;
        CFG_MAX_RAW:     max_raw_r     <= cfg_wdata;
        CFG_THRUST_MODE: thrust_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global pipeline enable: everything moves when the output slot is free
  // or being emptied this cycle.
  // ---------------------------------------------------------------------------
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: numerator and divisor as signed differences
  // ---------------------------------------------------------------------------
  logic [RAW_W-1:0]         raw;
  logic signed [DIFF_W-1:0] raw_s, lo_s, ce_s, hi_s;
  logic signed [DIFF_W-1:0] num1, den1;

  assign raw   = in_tdata & RAW_MASK;
  assign raw_s = signed'({1'b0, raw});
  assign lo_s  = signed'({1'b0, min_raw_r});
  assign ce_s  = signed'({1'b0, center_raw_r});
  assign hi_s  = signed'({1'b0, max_raw_r});

  always_comb begin
    if (thrust_mode_r) begin
      num1 = raw_s - lo_s;
      den1 = hi_s - lo_s;
    end else begin
      num1 = raw_s - ce_s;
      den1 = (raw < center_raw_r) ? (ce_s - lo_s) : (hi_s - ce_s);
    end
  end

  logic                     s1_v_r;
  logic signed [DIFF_W-1:0] s1_num_r, s1_den_r;
  logic                     s1_nosig_r, s1_thrust_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num_r    <= num1;
      s1_den_r    <= den1;
      s1_nosig_r  <= (raw == '0);
      s1_thrust_r <= thrust_mode_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitudes, sign, fixed results (no signal, zero span)
  // ---------------------------------------------------------------------------
  jan_side_t        side2;
  logic [RAW_W-1:0] nabs2, dabs2;

  assign nabs2 = RAW_W'(s1_num_r[DIFF_W-1] ? -s1_num_r : s1_num_r);
  assign dabs2 = RAW_W'(s1_den_r[DIFF_W-1] ? -s1_den_r : s1_den_r);

  always_comb begin
    side2.nosig   = s1_nosig_r;
    side2.thrust  = s1_thrust_r;
    side2.neg     = s1_num_r[DIFF_W-1] ^ s1_den_r[DIFF_W-1];
    side2.ovr     = 1'b0;
    side2.ovr_pos = '0;
    if (s1_nosig_r) begin
      side2.ovr = 1'b1;
    end else if (s1_den_r == '0) begin
      // zero span: lower clamp for negative numerator, upper otherwise
      side2.ovr = 1'b1;
      if (s1_num_r[DIFF_W-1]) begin
        side2.ovr_pos = s1_thrust_r ? '0 : POS_MIN;
      end else begin
        side2.ovr_pos = POS_MAX;
      end
    end
  end

  logic             s2_v_r;
  logic [RAW_W-1:0] s2_nabs_r, s2_dabs_r;
  jan_side_t        s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_nabs_r <= nabs2;
      s2_dabs_r <= dabs2;
      s2_side_r <= side2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: rounding operands, round(100n/d) = floor((200n + d) / 2d)
  // ---------------------------------------------------------------------------
  logic             s3_v_r;
  logic [NUM_W-1:0] s3_num_r;
  logic [DEN_W-1:0] s3_den_r;
  jan_side_t        s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_r  <= NUM_W'(s2_nabs_r * NUM_W'(SCALE2)) + NUM_W'(s2_dabs_r);
      s3_den_r  <= {s2_dabs_r, 1'b0};
      s3_side_r <= s2_side_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4..11: bit-per-stage divider
  // ---------------------------------------------------------------------------
  logic             dv_valid;
  logic [QBITS-1:0] dv_q;
  logic             dv_sat;
  jan_side_t        dv_side;

  jan_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_num    (s3_num_r),
    .in_den    (s3_den_r),
    .in_side   (s3_side_r),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_sat   (dv_sat),
    .out_side  (dv_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 12: clamp, sign, output register
  // ---------------------------------------------------------------------------
  logic [QBITS-1:0]        qc;
  logic signed [POS_W-1:0] pos12;

  assign qc = (dv_sat || dv_q > Q_MAX) ? Q_MAX : dv_q;

  always_comb begin
    if (dv_side.ovr) begin
      pos12 = dv_side.ovr_pos;
    end else if (dv_side.neg) begin
      pos12 = dv_side.thrust ? '0 : -signed'({1'b0, qc});
    end else begin
      pos12 = signed'({1'b0, qc});
    end
  end

  logic                    out_tvalid_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic                    out_nosig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_r   <= pos12;
      out_nosig_r <= dv_side.nosig;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-POS_W-1){1'b0}}, out_nosig_r, out_pos_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_nosig_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_nosig_r |-> out_pos_r == '0)
    else $error("no-signal word with nonzero position");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_pos_r >= POS_MIN) && (out_pos_r <= POS_MAX))
    else $error("position out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s1_v_r && !dv_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== bench/joystick_axis_normalizer_checker.sv =====
// Watches the calibration port and both streams, predicts each output word
// from a local copy of the calibration and compares in order.
module joystick_axis_normalizer_checker import jan_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [RAW_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [RAW_W-1:0]       in_tdata,   // [15:0] raw_sample
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] position, [8] no_signal
  output int                     mismatches,
  output int                     pending_words
);

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    no_signal;
  } axis_word_t;

  logic [RAW_W-1:0] cal_min    = MIN_RAW_RST;
  logic [RAW_W-1:0] cal_center = CENTER_RAW_RST;
  logic [RAW_W-1:0] cal_max    = MAX_RAW_RST;
  logic             cal_thrust = 1'b0;

  axis_word_t axis_words_due[$];

  // round(100*num/den), halves away from zero, then clamp
  function automatic logic signed [POS_W-1:0] ratio_to_hundredths(
    input int num, input int den, input int lo, input int hi);
    longint n, d, q;
    bit     neg;
    if (den == 0) begin
      q = (num < 0) ? longint'(lo) : longint'(hi);
      return q[POS_W-1:0];
    end
    n   = longint'(num) * 100;
    d   = longint'(den);
    neg = (n < 0) != (d < 0);
    if (n < 0) n = -n;
    if (d < 0) d = -d;
    q = (2 * n + d) / (2 * d);
    if (neg) q = -q;
    if (q < longint'(lo)) q = longint'(lo);
    if (q > longint'(hi)) q = longint'(hi);
    return q[POS_W-1:0];
  endfunction

  function automatic axis_word_t calibrate_sample(input logic [RAW_W-1:0] sample);
    axis_word_t w;
    int raw, lo, ce, hi, den;
    raw = int'(sample) & ((1 << SAMPLE_BITS) - 1);
    lo  = int'(cal_min);
    ce  = int'(cal_center);
    hi  = int'(cal_max);
    w.no_signal = 1'b0;
    if (raw == 0) begin
      w.position  = '0;
      w.no_signal = 1'b1;
    end else if (cal_thrust) begin
      w.position = ratio_to_hundredths(raw - lo, hi - lo, 0, 100);
    end else begin
      den = (raw < ce) ? (ce - lo) : (hi - ce);
      w.position = ratio_to_hundredths(raw - ce, den, -100, 100);
    end
    return w;
  endfunction

  always @(posedge clk) begin
    axis_word_t seen, want;
    if (!rst_n) begin
      cal_min    = MIN_RAW_RST;
      cal_center = CENTER_RAW_RST;
      cal_max    = MAX_RAW_RST;
      cal_thrust = 1'b0;
      axis_words_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_MIN_RAW:     cal_min    = cfg_wdata;
          CFG_CENTER_RAW:  cal_center = cfg_wdata;
          CFG_MAX_RAW:     cal_max    = cfg_wdata;
          CFG_THRUST_MODE: cal_thrust = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        axis_words_due.push_back(calibrate_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        seen.position  = out_tdata[POS_W-1:0];
        seen.no_signal = out_tdata[POS_W];
        if (axis_words_due.size() == 0) begin
          $display("%0t: output word with none due: position %0d no_signal %0b",
                   $time, $signed(seen.position), seen.no_signal);
          mismatches++;
        end else begin
          want = axis_words_due.pop_front();
          if (seen.position !== want.position) begin
            $display("%0t: position expected %0d, got %0d",
                     $time, $signed(want.position), $signed(seen.position));
            mismatches++;
          end
          if (seen.no_signal !== want.no_signal) begin
            $display("%0t: no_signal expected %0b, got %0b",
                     $time, want.no_signal, seen.no_signal);
            mismatches++;
          end
        end
      end
    end
    pending_words <= axis_words_due.size();
  end

endmodule

// ===== bench/joystick_axis_normalizer_tb.sv =====
// Stimulus and verdict for the axis normalizer. The checker beside the
// block does all prediction; this module only drives words and ports.
module joystick_axis_normalizer_tb;
  import jan_pkg::*;

  localparam int LATENCY     = 12;    // accepted word to output word
  localparam int STALL_LIMIT = 2000;  // cycles with no word moving

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [RAW_W-1:0]       cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [RAW_W-1:0]       in_tdata   = '0;   // [15:0] raw_sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [7:0] position, [8] no_signal

  int mismatches;
  int pending_words;

  // current calibration, kept only to aim samples at interesting spots
  logic [RAW_W-1:0] cur_min    = MIN_RAW_RST;
  logic [RAW_W-1:0] cur_center = CENTER_RAW_RST;
  logic [RAW_W-1:0] cur_max    = MAX_RAW_RST;

  int burst_left     = 0;
  int samples_sent   = 0;
  int settings_used  = 1;  // reset calibration counts as the first
  int idle_cycles    = 0;
  int ready_mode     = 0;
  int ready_tick     = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  joystick_axis_normalizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  joystick_axis_normalizer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  // Receiver: a new stall pattern whenever its random hold counter runs out. Mode 0 never
  // stalls; the others take words at random, rarely, or on a 3-of-5 beat.
  always @(posedge clk) begin
    if (ready_tick == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_tick <= $urandom_range(20, 80);
    end else begin
      ready_tick <= ready_tick - 1;
    end
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (ready_tick % 5) < 3;
    endcase
  end

  // Watchdog: any word moving on either side counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One sample word. Bursts of random length with random gaps between
  // them; tready is looked at mid-cycle, where it is settled.
  task automatic send_sample(input logic [RAW_W-1:0] raw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    samples_sent++;
  endtask

  // Sender holds off until every due word is out, then lets the pipe empty.
  // The first edge lets the checker count a word taken on the last edge.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [RAW_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Only called with the block idle. Upper bits of the mode write are junk
  // on purpose: only bit 0 should count.
  task automatic load_calibration(input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] ce,
                                  input logic [RAW_W-1:0] hi, input logic thrust);
    logic [RAW_W-1:0] mode_word;
    mode_word    = RAW_W'($urandom);
    mode_word[0] = thrust;
    write_reg(CFG_MIN_RAW, lo);
    write_reg(CFG_CENTER_RAW, ce);
    write_reg(CFG_MAX_RAW, hi);
    write_reg(CFG_THRUST_MODE, mode_word);
    cfg_wr_en  <= 1'b0;
    cur_min    = lo;
    cur_center = ce;
    cur_max    = hi;
    settings_used++;
  endtask

  // First two random settings are the all-zero and all-ones extremes;
  // later ones mix ordered, tiny-span, unordered and inverted layouts.
  task automatic random_calibration(input int phase);
    logic [RAW_W-1:0] a, b, c, t;
    int sel;
    sel = (phase < 2) ? phase : $urandom_range(2, 8);
    a = RAW_W'($urandom);
    b = RAW_W'($urandom);
    c = RAW_W'($urandom);
    case (sel)
      0: begin a = 16'd0; b = 16'd0; c = 16'd0; end
      1: begin a = 16'hFFFF; b = 16'hFFFF; c = 16'hFFFF; end
      2: begin a = MIN_RAW_RST; b = CENTER_RAW_RST; c = MAX_RAW_RST; end
      3: begin
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
      end
      4: begin
        // spans of at most 200 counts: rounding halves show up often
        a = RAW_W'($urandom_range(0, 65000));
        b = RAW_W'(a + $urandom_range(0, 200));
        c = RAW_W'(b + $urandom_range(0, 200));
      end
      5: ;  // fully unordered
      6: begin
        a = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
        b = ($urandom_range(0, 2) == 0) ? 16'd0 : b;
        c = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'd0;
      end
      7: begin a = 16'd0; c = 16'hFFFF; end
      default: begin
        // inverted: high end below low end
        c = RAW_W'($urandom_range(0, 65000));
        b = RAW_W'(c + $urandom_range(0, 200));
        a = RAW_W'(b + $urandom_range(0, 200));
      end
    endcase
    load_calibration(a, b, c, (phase % 2) == 1);
  endtask

  // Mostly samples inside the calibrated travel, plus no-signal words,
  // the calibration points themselves and full-range noise.
  function automatic logic [RAW_W-1:0] pick_raw();
    logic [31:0] r;
    int sel, v;
    sel = $urandom_range(0, 19);
    r   = $urandom;
    case (sel)
      0:       r = 0;
      1:       r = 32'hFFFF;
      2, 3:    ;
      4:       r = {16'd0, cur_min};
      5:       r = {16'd0, cur_center};
      6:       r = {16'd0, cur_max};
      7, 8: begin
        v = int'(cur_center) + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        r = v;
      end
      9:       r = $urandom_range(1, 15);
      default: r = $urandom_range(cur_min, cur_max);
    endcase
    return r[RAW_W-1:0];
  endfunction

  initial begin
    int p, n, k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration, bipolar: no signal, ends, and both sides of rest
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'd32766);
    send_sample(16'd32767);
    send_sample(16'd32768);
    send_sample(16'd16384);
    send_sample(16'd49151);
    send_sample(16'hFFFF);
    drain_pipeline();

    // thrust: below travel clamps to 0, 1010 and 1030 sit on rounding halves
    load_calibration(16'd1000, 16'd2000, 16'd3000, 1'b1);
    send_sample(16'd0);
    send_sample(16'd999);
    send_sample(16'd1000);
    send_sample(16'd1010);
    send_sample(16'd1030);
    send_sample(16'd2000);
    send_sample(16'd3000);
    send_sample(16'hFFFF);
    drain_pipeline();

    // zero span on both halves: negative numerator low clamp, else high
    load_calibration(16'd5000, 16'd5000, 16'd5000, 1'b0);
    send_sample(16'd4999);
    send_sample(16'd5000);
    send_sample(16'd5001);
    drain_pipeline();

    // inverted calibration, bipolar: sign follows numerator and divisor
    load_calibration(16'd60000, 16'd30000, 16'd100, 1'b0);
    send_sample(16'd40000);
    send_sample(16'd20000);
    drain_pipeline();

    // inverted calibration, thrust
    load_calibration(16'd50000, 16'd0, 16'd10000, 1'b1);
    send_sample(16'd30000);
    send_sample(16'd60000);
    send_sample(16'hFFFF);
    drain_pipeline();

    // random calibrations, alternating bipolar and thrust
    for (p = 0; p < 14; p++) begin
      random_calibration(p);
      n = $urandom_range(70, 110);
      for (k = 0; k < n; k++) send_sample(pick_raw());
      drain_pipeline();
    end

    $display("Sent %0d raw samples over %0d calibrations, bipolar and thrust,",
             samples_sent, settings_used);
    $display("with zero and inverted spans, no-signal words and stalls on both sides.");
    if (pending_words != 0)
      $display("%0t: %0d output words never arrived", $time, pending_words);
    if (mismatches == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
